/* design/assert_macros.svh */
// assertion macros for the write buffer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

/* design/iosmwb_pkg.sv */
// package: types and constants of the merging i/o write buffer
package iosmwb_pkg;
    localparam int SLOTS_DEF = 4;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam logic [6:0] LONG_WINDOW = 7'd32;

    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_ISSUE  = 2'd1;
    localparam logic [1:0] KIND_FREE   = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_MERGED = 3'd0;
    localparam logic [2:0] ST_ALLOC  = 3'd1;
    localparam logic [2:0] ST_OVER   = 3'd2;
    localparam logic [2:0] ST_ISSUED = 3'd3;
    localparam logic [2:0] ST_NONE   = 3'd4;
    localparam logic [2:0] ST_FREED  = 3'd5;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_QUAD = 2'd3;

    localparam logic [1:0] CMD_BYTES = 2'd0;
    localparam logic [1:0] CMD_LONGS = 2'd1;
    localparam logic [1:0] CMD_QUADS = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [43:0] address;
        logic [63:0] store_data;
        logic [1:0]  size_code;
        logic [6:0]  tag;
        logic [1:0]  entry;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot;
        logic [1:0]  command;
        logic [43:0] block_address;
        logic [63:0] byte_mask;
        logic [6:0]  byte_length;
        logic [63:0] data_word;
        logic [6:0]  done_tag;
        logic        last;
    } t_resp;

    // merge test result from the shared compare unit
    typedef struct packed {
        logic hit;
        logic [6:0] offset;
    } t_cmp;
endpackage

/* design/iosmwb_cmp.sv */
// shared merge compare unit: tests one entry against a store
module iosmwb_cmp import iosmwb_pkg::*; (
    input  logic [43:0] i_slot_addr,
    input  logic [6:0]  i_slot_len,
    input  logic [1:0]  i_slot_size,
    input  logic        i_slot_ok,
    input  logic [43:0] i_pa,
    input  logic [1:0]  i_code,
    input  logic [6:0]  i_window,
    output t_cmp        o_cmp
);
    logic [44:0] w_end, w_pend, w_lim;
    logic [3:0]  w_len;
    always_comb begin
        w_len  = 4'd1 << i_code;
        w_end  = {1'b0, i_slot_addr} + {38'd0, i_slot_len};
        w_pend = {1'b0, i_pa} + {41'd0, w_len};
        w_lim  = {1'b0, i_slot_addr} + {38'd0, i_window};
        o_cmp.hit = i_slot_ok && (i_slot_size == i_code) &&
                    !(w_end > {1'b0, i_pa}) && !(w_pend > w_lim);
        o_cmp.offset = 7'(i_pa - i_slot_addr);
    end
endmodule

/* design/io_store_merge_write_buffer.sv */
// top level of the merging i/o write buffer
// store: an entry scan, then the write of the data rows, then the result
// issue: an entry scan, then BLOCK_BYTES/8 results, or one none result if no entry waits
// free: the top pointer advances past freed entries, then the result
// sequential, one request at a time
// synchronous active-low reset clears valid, processed, pointers and config
`include "assert_macros.svh"
module io_store_merge_write_buffer import iosmwb_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_req  i_req,
    output logic  o_valid,
    input  logic  i_stall,
    output t_resp o_resp,
    input  logic  i_cfg_we,
    input  logic  i_cfg_data
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORDS = BLOCK_BYTES / 8;
    localparam int KW = $clog2(WORDS);

    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_WRITE = 3'd2,
                           S_OUT = 3'd3, S_ADV = 3'd4, S_RESP = 3'd5;

    // slot state
    logic [43:0] r_addr [SLOTS];
    logic [1:0]  r_size [SLOTS];
    logic [6:0]  r_len  [SLOTS];
    logic [63:0] r_mask [SLOTS];
    logic [6:0]  r_tag  [SLOTS];
    logic [SLOTS-1:0] r_valid, r_proc;
    logic [SW-1:0] r_top, r_bot;
    logic r_limit;
    // data bytes: one memory, eight bytes wide, written one quadword row at a time
    logic [63:0] r_mem [SLOTS*WORDS];

    logic [2:0]  r_state;
    t_req        r_req;
    logic [SW:0] r_i;          // scan step count
    logic [SW-1:0] r_s;        // chosen slot
    logic [6:0]  r_off;
    logic [KW:0] r_k;
    logic [1:0]  r_wstep;      // store write: up to two rows touched
    logic        r_merge;
    logic [63:0] r_rd;
    t_resp       r_out;
    logic        r_ov;

    logic [SW:0] w_span;
    logic [SW-1:0] w_p;
    logic [6:0]  w_win;
    t_cmp        w_cmp;
    logic [3:0]  w_len;

    assign w_span = SW'((r_bot - r_top)) + (SW+1)'(1);
    assign w_p = SW'(r_top + SW'(r_i));
    assign w_len = 4'd1 << r_req.size_code;
    assign w_win = (r_req.size_code == SZ_QUAD && !r_limit) ? 7'(BLOCK_BYTES) : LONG_WINDOW;

    iosmwb_cmp u_cmp (
        .i_slot_addr(r_addr[w_p]), .i_slot_len(r_len[w_p]), .i_slot_size(r_size[w_p]),
        .i_slot_ok(r_valid[w_p] && !r_proc[w_p]), .i_pa(r_req.address),
        .i_code(r_req.size_code), .i_window(w_win), .o_cmp(w_cmp)
    );

    assign o_stall = (r_state != S_IDLE) || r_ov;
    assign o_valid = r_ov;
    assign o_resp = r_out;

    // shifted store data and byte enables over two quadword rows
    logic [127:0] w_sh;
    logic [15:0]  w_be;
    logic [KW:0]  w_row;
    logic [63:0]  w_wd, w_bm;
    always_comb begin
        w_sh = {64'd0, r_req.store_data} << {r_off[2:0], 3'b000};
        w_be = {8'd0, 8'((9'd1 << w_len) - 9'd1)} << r_off[2:0];
        w_row = (KW+1)'(r_off[6:3]) + (KW+1)'(r_wstep[0]);
        w_wd = r_wstep[0] ? w_sh[127:64] : w_sh[63:0];
        w_bm = '0;
        for (int b = 0; b < 8; b++)
            w_bm[8*b +: 8] = {8{r_wstep[0] ? w_be[8+b] : w_be[b]}};
    end

    logic [63:0] w_rmask;
    always_comb begin
        w_rmask = '0;
        for (int b = 0; b < 8; b++)
            w_rmask[8*b +: 8] = {8{r_mask[r_s][8*r_k[KW-1:0] + b]}};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE && w_row < (KW+1)'(WORDS) && (|w_be[8*r_wstep[0] +: 8]))
            r_mem[{r_s, w_row[KW-1:0]}] <=
                (r_mem[{r_s, w_row[KW-1:0]}] & ~w_bm) | (w_wd & w_bm);
        r_rd <= r_mem[{r_s, r_k[KW-1:0]}];
    end

    logic [63:0] w_nbits;
    assign w_nbits = (64'((65'd1 << w_len) - 65'd1)) << r_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_proc <= '0;
            r_top <= '0; r_bot <= '0; r_limit <= 1'b0; r_ov <= 1'b0;
            for (int j = 0; j < SLOTS; j++) begin
                r_addr[j] <= '0; r_size[j] <= '0; r_len[j] <= '0;
                r_mask[j] <= '0; r_tag[j] <= '0;
            end
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_req <= i_req;
                        r_i <= '0;
                        r_out <= '0;
                        case (i_req.kind)
                            KIND_STORE: r_state <= S_SCAN;
                            KIND_ISSUE: r_state <= S_SCAN;
                            KIND_FREE: begin
                                r_s <= SW'(i_req.entry);
                                r_valid[SW'(i_req.entry)] <= 1'b0;
                                r_state <= S_ADV;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_req.kind == KIND_STORE) begin
                        if (r_req.size_code >= SZ_LONG && r_i < w_span && w_cmp.hit) begin
                            r_s <= w_p; r_off <= w_cmp.offset; r_merge <= 1'b1;
                            r_wstep <= '0; r_state <= S_WRITE;
                        end else if (r_req.size_code < SZ_LONG || r_i >= w_span) begin
                            // allocate
                            logic [SW-1:0] nb;
                            nb = r_valid[r_bot] ? SW'(r_bot + SW'(1)) : r_bot;
                            r_bot <= nb; r_s <= nb; r_off <= '0; r_merge <= 1'b0;
                            r_out.status <= r_valid[nb] ? ST_OVER : ST_ALLOC;
                            r_addr[nb] <= r_req.address; r_size[nb] <= r_req.size_code;
                            r_len[nb] <= 7'(w_len); r_tag[nb] <= r_req.tag;
                            r_mask[nb] <= 64'((65'd1 << w_len) - 65'd1);
                            r_proc[nb] <= 1'b0; r_valid[nb] <= 1'b1;
                            r_wstep <= '0; r_state <= S_WRITE;
                        end else r_i <= r_i + 1'b1;
                    end else begin
                        if (r_i >= w_span) begin
                            r_out.status <= ST_NONE; r_out.last <= 1'b1;
                            r_ov <= 1'b1; r_state <= S_RESP;
                        end else if (r_valid[w_p] && !r_proc[w_p]) begin
                            r_s <= w_p; r_proc[w_p] <= 1'b1; r_k <= '0;
                            r_state <= S_OUT;
                        end else r_i <= r_i + 1'b1;
                    end
                end
                S_WRITE: begin
                    if (r_wstep == 2'd0 && r_merge) begin
                        r_len[r_s] <= r_off + 7'(w_len);
                        r_mask[r_s] <= r_mask[r_s] | w_nbits;
                        r_out.status <= ST_MERGED;
                    end
                    if (r_wstep == 2'd1) begin
                        r_out.slot <= r_s; r_out.last <= 1'b1;
                        r_ov <= 1'b1; r_state <= S_RESP;
                    end else r_wstep <= r_wstep + 2'd1;
                end
                S_OUT: begin
                    // r_rd holds row r_k in the cycle after its address is set
                    if (!r_ov && r_wstep == 2'd3) begin
                        r_out.status <= ST_ISSUED; r_out.slot <= r_s;
                        r_out.command <= (r_size[r_s] == SZ_QUAD) ? CMD_QUADS :
                                         (r_size[r_s] == SZ_LONG) ? CMD_LONGS : CMD_BYTES;
                        r_out.block_address <= r_addr[r_s];
                        r_out.byte_mask <= r_mask[r_s];
                        r_out.byte_length <= r_len[r_s];
                        r_out.data_word <= r_rd & w_rmask;
                        r_out.last <= (r_k == (KW+1)'(WORDS-1));
                        r_ov <= 1'b1;
                        r_wstep <= '0;
                        if (r_k == (KW+1)'(WORDS-1)) r_state <= S_RESP;
                        else r_k <= r_k + 1'b1;
                    end else if (!r_ov) r_wstep <= 2'd3;
                end
                S_ADV: begin
                    if (r_i < w_span && !r_valid[w_p]) r_i <= r_i + 1'b1;
                    else begin
                        r_top <= w_p;
                        r_out.status <= ST_FREED; r_out.slot <= r_s;
                        r_out.done_tag <= r_tag[r_s]; r_out.last <= 1'b1;
                        r_ov <= 1'b1; r_state <= S_RESP;
                    end
                end
                S_RESP: if (!r_ov || !i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_idle_no_out, i_clk, i_rst_n, (r_state == S_IDLE) && r_ov)
    `ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_stall)
    `ASSERT_IMPL(a_issue_proc, i_clk, i_rst_n, (r_state == S_OUT) |-> r_proc[r_s])
endmodule

/* sim/testbench.sv */
// self-checking testbench for the merging i/o write buffer
`timescale 1ns / 1ps
module testbench;
    import iosmwb_pkg::*;

    // clock, reset and block ports
    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_req  i_req = '0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_resp o_resp;
    logic  i_cfg_we = 1'b0;
    logic  i_cfg_data = 1'b0;

    always #5 i_clk = ~i_clk;

    io_store_merge_write_buffer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_req(i_req),
        .o_valid(o_valid), .i_stall(i_stall), .o_resp(o_resp),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // shadow copy of the buffer ring
    logic [43:0] ring_addr [4];
    logic [1:0]  ring_size [4];
    logic [6:0]  ring_len  [4];
    logic [63:0] ring_mask [4];
    logic        ring_valid[4];
    logic        ring_done [4];
    logic [6:0]  ring_tag  [4];
    logic [7:0]  ring_bytes[4][64];
    logic [1:0]  top_ptr, bot_ptr;
    logic        quad_limit32;

    // responses waiting to be seen at the output
    t_resp pending_resp[$];
    int    mismatches = 0;
    int    sent = 0, checked = 0, merges = 0, overwrites = 0;

    // idle rates in percent; hold count for the long receiver pause
    int send_idle = 0, recv_idle = 0, hold_cycles = 0;

    function automatic logic [2:0] span();
        return 3'(2'(bot_ptr - top_ptr)) + 3'd1;
    endfunction

    function automatic t_resp blank(logic [2:0] st, logic [1:0] sl);
        t_resp r;
        r = '0;
        r.status = st;
        r.slot   = sl;
        r.last   = 1'b1;
        return r;
    endfunction

    // compute the expected responses of one request and update the ring
    task automatic predict_buffer(input t_req rq);
        logic [1:0]  s;
        int          len, off, win, k, b, i;
        logic [63:0] w;
        t_resp       r;
        bit          hit;
        hit = 0;
        case (rq.kind)
            KIND_STORE: begin
                len = 1 << rq.size_code;
                if (rq.size_code >= SZ_LONG) begin
                    win = (rq.size_code == SZ_QUAD && !quad_limit32) ? 64 : 32;
                    for (i = 0; i < span() && !hit; i++) begin
                        s = 2'(top_ptr + i);
                        if (ring_valid[s] && !ring_done[s] && ring_size[s] == rq.size_code
                            && {1'b0, ring_addr[s]} + ring_len[s] <= {1'b0, rq.address}
                            && {1'b0, rq.address} + len <= {1'b0, ring_addr[s]} + win) begin
                            off = int'(rq.address - ring_addr[s]);
                            for (b = 0; b < len; b++)
                                ring_bytes[s][off + b] = rq.store_data[8*b +: 8];
                            ring_len[s] = 7'(off + len);
                            ring_mask[s] |= ((64'd1 << len) - 64'd1) << off;
                            pending_resp.push_back(blank(ST_MERGED, s));
                            merges++;
                            hit = 1;
                        end
                    end
                end
                if (!hit) begin
                    if (ring_valid[bot_ptr]) bot_ptr = bot_ptr + 2'd1;
                    s = bot_ptr;
                    if (ring_valid[s]) overwrites++;
                    pending_resp.push_back(blank(ring_valid[s] ? ST_OVER : ST_ALLOC, s));
                    ring_addr[s] = rq.address;
                    ring_size[s] = rq.size_code;
                    ring_len[s]  = 7'(len);
                    ring_tag[s]  = rq.tag;
                    for (b = 0; b < len; b++) ring_bytes[s][b] = rq.store_data[8*b +: 8];
                    ring_mask[s]  = (len == 8) ? 64'hFF : ((64'd1 << len) - 64'd1);
                    ring_done[s]  = 1'b0;
                    ring_valid[s] = 1'b1;
                end
            end
            KIND_ISSUE: begin
                for (i = 0; i < span() && !hit; i++) begin
                    s = 2'(top_ptr + i);
                    if (ring_valid[s] && !ring_done[s]) begin
                        ring_done[s] = 1'b1;
                        hit = 1;
                        for (k = 0; k < 8; k++) begin
                            w = '0;
                            for (b = 0; b < 8; b++)
                                if (ring_mask[s][8*k + b]) w[8*b +: 8] = ring_bytes[s][8*k + b];
                            r = blank(ST_ISSUED, s);
                            r.command = (ring_size[s] == SZ_QUAD) ? CMD_QUADS :
                                        (ring_size[s] == SZ_LONG) ? CMD_LONGS : CMD_BYTES;
                            r.block_address = ring_addr[s];
                            r.byte_mask     = ring_mask[s];
                            r.byte_length   = ring_len[s];
                            r.data_word     = w;
                            r.last          = (k == 7);
                            pending_resp.push_back(r);
                        end
                    end
                end
                if (!hit) pending_resp.push_back(blank(ST_NONE, 2'd0));
            end
            KIND_FREE: begin
                s = rq.entry;
                ring_valid[s] = 1'b0;
                for (i = 0; i < span(); i++)
                    if (ring_valid[2'(top_ptr + i)]) break;
                top_ptr = 2'(top_ptr + i);
                r = blank(ST_FREED, s);
                r.done_tag = ring_tag[s];
                pending_resp.push_back(r);
            end
            default: ;
        endcase
    endtask

    // send one request; valid stays up across back-to-back requests
    task automatic send_request(input t_req rq);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= rq;
        predict_buffer(rq);
        sent++;
        do @(posedge i_clk); while (o_stall);
    endtask

    // receiver stall pattern, with an optional long hold
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
        end
    end

    // check every accepted response against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_resp e;
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_resp);
                mismatches++;
            end else begin
                e = pending_resp.pop_front();
                checked++;
                if (o_resp !== e) begin
                    $display("%0t: response mismatch expected %h actual %h", $time, e, o_resp);
                    if (o_resp.status !== e.status)
                        $display("%0t:   status expected %0d actual %0d",
                                 $time, e.status, o_resp.status);
                    if (o_resp.data_word !== e.data_word)
                        $display("%0t:   data_word expected %h actual %h",
                                 $time, e.data_word, o_resp.data_word);
                    mismatches++;
                end
            end
        end
    end

    function automatic t_req make_store(logic [43:0] a, logic [1:0] sz, logic [63:0] d);
        t_req r;
        r = '0;
        r.kind = KIND_STORE;
        r.address = a;
        r.size_code = sz;
        r.store_data = d;
        r.tag = 7'($urandom_range(127));
        return r;
    endfunction

    function automatic t_req make_cmd(logic [1:0] k, logic [1:0] ent);
        t_req         r;
        logic [127:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom};
        r = rnd[$bits(t_req)-1:0];
        r.kind = k;
        r.entry = ent;
        return r;
    endfunction

    // wait for all responses, plus slack for a free still walking the top
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        quad_limit32 = v;
    endtask

    // extremes, every request kind, overwrite, double free, unknown kind
    task automatic test_directed();
        t_req r;
        int   i;
        send_request(make_cmd(KIND_ISSUE, 2'd0));                     // empty ring
        send_request(make_store(44'hFFF_FFFF_FFC0, SZ_QUAD, '1));
        send_request(make_store(44'hFFF_FFFF_FFC8, SZ_QUAD, 64'h0123_4567_89AB_CDEF));
        send_request(make_store(44'hFFF_FFFF_FFF8, SZ_QUAD, '0));      // window end
        send_request(make_store(44'h0, SZ_BYTE, 64'hA5));              // byte
        send_request(make_store(44'h1, SZ_WORD, 64'h5A5A));            // word never merges
        send_request(make_store(44'h100, SZ_LONG, 64'hDEAD_BEEF));
        send_request(make_store(44'h11C, SZ_LONG, 64'hCAFE_F00D));     // longword window end
        send_request(make_store(44'h104, SZ_LONG, 64'h1));             // below end: allocates
        for (i = 0; i < 5; i++) send_request(make_cmd(KIND_ISSUE, 2'd0));
        r = make_cmd(KIND_UNUSED, 2'd0);                               // unknown kind
        send_request(r);
        send_request(make_cmd(KIND_FREE, 2'd3));
        send_request(make_cmd(KIND_FREE, 2'd3));                       // double free
        for (i = 0; i < 4; i++) send_request(make_cmd(KIND_FREE, 2'(i)));
        send_request(make_store(44'h40, SZ_QUAD, 64'h1111));
        send_request(make_cmd(KIND_ISSUE, 2'd0));
    endtask

    // mostly ascending store bursts, mixed with issue and free, with some noise
    task automatic test_random(input int n);
        logic [43:0]  base;
        logic [1:0]   sz;
        int           i, j, step;
        t_req         r;
        logic [127:0] rnd;
        i = 0;
        while (i < n) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    base = 44'({$urandom, $urandom}) & 44'hFFF_FFFF_FFE0;
                    if ($urandom_range(3) == 0) base = $urandom_range(1) ? '1 : '0;
                    sz = $urandom_range(3) < 3 ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
                    for (j = 0; j < $urandom_range(1, 6) && i < n; j++) begin
                        r = make_store(base, sz, {$urandom, $urandom});
                        send_request(r);
                        step = (1 << sz) * $urandom_range(1, 2);
                        if ($urandom_range(7) == 0) step = -step;
                        base = base + 44'(step);
                        i++;
                    end
                end
                5, 6: begin send_request(make_cmd(KIND_ISSUE, 2'd0)); i++; end
                7, 8: begin send_request(make_cmd(KIND_FREE, 2'($urandom_range(3)))); i++; end
                default: begin
                    rnd = {$urandom, $urandom, $urandom, $urandom};
                    r = rnd[$bits(t_req)-1:0];
                    send_request(r);
                    if (r.kind != KIND_UNUSED) i++;
                end
            endcase
        end
    endtask

    // long receiver hold while requests keep coming, so the block backs up
    task automatic test_backpressure();
        int i;
        hold_cycles = 200;
        for (i = 0; i < 4; i++) send_request(make_store(44'h200 + 44'(64*i), SZ_QUAD, '1));
        for (i = 0; i < 4; i++) send_request(make_cmd(KIND_ISSUE, 2'd0));
        for (i = 0; i < 4; i++) send_request(make_cmd(KIND_FREE, 2'(i)));
    endtask

    initial begin
        int s;
        for (s = 0; s < 4; s++) begin
            ring_addr[s] = '0; ring_size[s] = '0; ring_len[s] = '0; ring_mask[s] = '0;
            ring_valid[s] = 1'b0; ring_done[s] = 1'b0; ring_tag[s] = '0;
            for (int b = 0; b < 64; b++) ring_bytes[s][b] = '0;
        end
        top_ptr = '0; bot_ptr = '0; quad_limit32 = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 28; recv_idle = 87;
        test_directed();
        write_limit(1'b1);
        test_random(80);
        send_idle = 87; recv_idle = 28;
        write_limit(1'b0);
        test_random(70);
        send_idle = 0; recv_idle = 0;
        test_backpressure();
        write_limit(1'b1);
        test_random(50);
        write_limit(1'b0);
        drain();

        $display("covered %0d requests, %0d responses, %0d merges, %0d overwrites",
                 sent, checked, merges, overwrites);
        $display("both merge window settings, long receiver hold and idle mixes exercised");
        if (mismatches == 0 && pending_resp.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // generous run limit
    initial begin
        #20ms;
        $display("%0t: timeout, %0d responses outstanding", $time, pending_resp.size());
        $display("Mismatches found");
        $finish;
    end
endmodule
